// ===== rtl/session_persistence_table_macros.svh =====
// Assertion macros for the session persistence table.
`ifndef SESSION_PERSISTENCE_TABLE_MACROS_SVH
`define SESSION_PERSISTENCE_TABLE_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define SPT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Check an implication in the next cycle.
`define SPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== rtl/spt_pkg.sv =====
// Package with types and constants of the session persistence table.
package spt_pkg;
   localparam int BUCKETS = 256;
   localparam int WAYS    = 4;

   typedef enum logic [2:0] {
      OP_GET     = 3'd0,
      OP_ADD     = 3'd1,
      OP_RELEASE = 3'd2,
      OP_DELETE  = 3'd3,
      OP_UPDATE  = 3'd4,
      OP_EXPIRE  = 3'd5,
      OP_DEL_BE  = 3'd6,
      OP_FLUSH   = 3'd7
   } op_type;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_MISS  = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [15:0] REFS_MAX = 16'hFFFF;
   localparam logic [10:0] LIVE_MAX = 11'd2047;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_HASH, S_RDH, S_RDHW, S_PROBE, S_WRH, S_SCANRD, S_SCANW,
      S_SCANCHK, S_RESP
   } state_type;

   typedef struct packed {
      logic        valid;
      logic        defunct;
      logic [63:0] key;
      logic [31:0] ip;
      logic [15:0] port;
      logic [31:0] stamp;
      logic [15:0] refs;
   } slot_type;
endpackage

// ===== rtl/spt_hash.sv =====
// Byte-serial djb2 hash unit over a normalized key.
module spt_hash #(
   parameter int KEY_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] key,
   output logic [63:0] norm_key,
   output logic [31:0] hash,
   output logic        done
);
   logic [3:0]  idx_ff, idx_in;
   logic [31:0] h_ff, h_in;
   logic [63:0] nk_ff, nk_in;
   logic        run_ff, run_in;
   logic [7:0]  b;

   assign b = key[8 * idx_ff[2:0] +: 8];
   assign norm_key = nk_ff;
   assign hash = h_ff;
   assign done = !run_ff;

   always_comb begin
      idx_in = idx_ff;
      h_in = h_ff;
      nk_in = nk_ff;
      run_in = run_ff;
      if (start) begin
         idx_in = '0;
         h_in = 32'd5381;
         nk_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (idx_ff >= 4'(KEY_BYTES) || b == 8'd0) begin
            run_in = 1'b0;
         end else begin
            h_in = (h_ff << 5) + h_ff + {24'd0, b};
            nk_in[8 * idx_ff[2:0] +: 8] = b;
            idx_in = idx_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
      idx_ff <= idx_in;
      h_ff <= h_in;
      nk_ff <= nk_in;
   end
endmodule

// ===== rtl/session_persistence_table.sv =====
// Top level of the session persistence table.
// Key lookups run the byte-serial hash up to the first zero byte or KEY_BYTES bytes, then
// read and probe the bucket's ways in turn through the single slot RAM port until a hit or
// the last way, then write back. Release reads the slot named by the handle and writes it
// back; sweep, delete-backend and flush read and check every slot. One request at a time:
// the next request is accepted only after the response is taken. Synchronous reset clears
// live count and register, then a clearing pass zeroes every slot while req_tready is low.
`include "session_persistence_table_macros.svh"
module session_persistence_table #(
   parameter int KEY_BYTES = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [31:0]  csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // op[2:0], session_key[66:3], backend_ip[98:67], backend_port[114:99],
   // entry_handle[124:115], new_time[156:125], now_seconds[188:157], zero pad
   input  logic [191:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], created[2], result_handle[12:3], found_ip[44:13],
   // found_port[60:45], live_sessions[71:61]
   output logic [71:0]  rsp_tdata
);
   localparam int BUCKETS = spt_pkg::BUCKETS;
   localparam int WAYS = spt_pkg::WAYS;
   localparam int SLOTS = BUCKETS * WAYS;
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

   // Slot storage; valid and defunct marks live in each entry.
   spt_pkg::slot_type mem [SLOTS];
   spt_pkg::slot_type rd_ff;
   logic [SW-1:0] addr;
   logic          we;
   spt_pkg::slot_type wr;

   logic [31:0] ttl_ff;
   spt_pkg::state_type st_ff, st_in;
   spt_pkg::op_type op_ff;
   logic [63:0] key_ff;
   logic [31:0] ip_ff, ntime_ff, now_ff;
   logic [15:0] port_ff;
   logic [9:0]  handle_ff;
   logic [SW-1:0] cur_ff, cur_in;
   logic [WW:0]   way_ff, way_in;
   logic [WW:0]   free_ff, free_in;
   logic [BW-1:0] bkt_ff;
   logic [10:0]   live_ff, live_in;
   logic [1:0]    status_ff, status_in;
   logic          created_ff, created_in, hit_ff, hit_in;
   logic [SW-1:0] hitidx_ff, hitidx_in;
   logic [31:0]   rip_ff, rip_in;
   logic [15:0]   rport_ff, rport_in;

   logic        hstart, hdone;
   logic [63:0] nkey;
   logic [31:0] hval;

   spt_hash #(.KEY_BYTES(KEY_BYTES)) u_hash (
      .clock(clock), .reset(reset), .start(hstart), .key(key_ff),
      .norm_key(nkey), .hash(hval), .done(hdone)
   );

   logic req_fire;
   assign req_fire = req_tvalid && req_tready;
   assign req_tready = (st_ff == spt_pkg::S_IDLE);
   assign rsp_tvalid = (st_ff == spt_pkg::S_RESP);
   assign rsp_tdata = {live_ff, rport_ff, rip_ff, hit_ff ? 10'(hitidx_ff) : 10'd0,
                       created_ff, status_ff};

   logic [SW-1:0] way_slot;
   assign way_slot = SW'(bkt_ff * WAYS) + SW'(way_ff);

   // Free decision: drop the live count for non-defunct slots, remove at zero refs.
   logic cur_v, cur_d, key_hit, sweep_hit;
   assign cur_v = rd_ff.valid;
   assign cur_d = rd_ff.defunct;
   assign key_hit = cur_v && !cur_d && rd_ff.key == nkey;
   always_comb begin
      sweep_hit = 1'b0;
      unique case (op_ff)
         spt_pkg::OP_EXPIRE: sweep_hit = cur_v && rd_ff.stamp != 0 &&
            now_ff >= rd_ff.stamp && (now_ff - rd_ff.stamp) > ttl_ff;
         spt_pkg::OP_DEL_BE: sweep_hit = cur_v && rd_ff.ip == ip_ff &&
            rd_ff.port == port_ff;
         default: sweep_hit = cur_v;
      endcase
   end

   // Next state.
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         spt_pkg::S_CLEAR: if (cur_ff == SW'(SLOTS - 1)) st_in = spt_pkg::S_IDLE;
         spt_pkg::S_IDLE: if (req_fire) begin
            if (req_tdata[2:0] == spt_pkg::OP_RELEASE) st_in = spt_pkg::S_RDH;
            else if (req_tdata[2:0] inside {spt_pkg::OP_EXPIRE, spt_pkg::OP_DEL_BE,
               spt_pkg::OP_FLUSH}) st_in = spt_pkg::S_SCANRD;
            else st_in = spt_pkg::S_HASH;
         end
         spt_pkg::S_HASH: if (hdone && !hstart) st_in = spt_pkg::S_RDHW;
         spt_pkg::S_RDHW: st_in = spt_pkg::S_PROBE;
         spt_pkg::S_PROBE: begin
            if (key_hit) st_in = spt_pkg::S_WRH;
            else if (way_ff == (WW+1)'(WAYS - 1)) st_in = spt_pkg::S_WRH;
            else st_in = spt_pkg::S_RDHW;
         end
         spt_pkg::S_RDH: st_in = spt_pkg::S_WRH;
         spt_pkg::S_WRH: st_in = spt_pkg::S_RESP;
         spt_pkg::S_SCANRD: st_in = spt_pkg::S_SCANCHK;
         spt_pkg::S_SCANCHK: st_in = (cur_ff == SW'(SLOTS - 1)) ? spt_pkg::S_SCANW
                                                              : spt_pkg::S_SCANRD;
         spt_pkg::S_SCANW: st_in = spt_pkg::S_RESP;
         spt_pkg::S_RESP: if (rsp_tready) st_in = spt_pkg::S_IDLE;
         default: st_in = spt_pkg::S_IDLE;
      endcase
   end

   logic hstart_ff;
   assign hstart = hstart_ff;

   // Datapath and outputs of the sequencer.
   always_comb begin
      cur_in = cur_ff; way_in = way_ff; free_in = free_ff; live_in = live_ff;
      status_in = status_ff; created_in = created_ff; hit_in = hit_ff;
      hitidx_in = hitidx_ff; rip_in = rip_ff; rport_in = rport_ff;
      we = 1'b0; wr = rd_ff; addr = cur_ff;
      unique case (st_ff)
         spt_pkg::S_CLEAR: begin
            we = 1'b1; wr = '0;
            cur_in = cur_ff + 1'b1;
         end
         spt_pkg::S_IDLE: begin
            status_in = spt_pkg::ST_OK; created_in = 1'b0; hit_in = 1'b0;
            way_in = '0; free_in = (WW+1)'(WAYS); rip_in = '0; rport_in = '0;
            cur_in = '0;
            if (req_tdata[2:0] == spt_pkg::OP_RELEASE) cur_in = SW'(req_tdata[124:115]);
         end
         spt_pkg::S_HASH: cur_in = way_slot;
         spt_pkg::S_RDHW: addr = cur_ff;
         spt_pkg::S_PROBE: begin
            if (!cur_v && free_ff == (WW+1)'(WAYS)) free_in = way_ff;
            if (key_hit) begin
               hit_in = 1'b1; hitidx_in = cur_ff;
            end else if (way_ff != (WW+1)'(WAYS - 1)) begin
               way_in = way_ff + 1'b1;
               cur_in = SW'(bkt_ff * WAYS) + SW'(way_ff + 1'b1);
            end
         end
         spt_pkg::S_RDH: addr = cur_ff;
         spt_pkg::S_WRH: begin
            addr = cur_ff;
            if (op_ff == spt_pkg::OP_RELEASE) begin
               if (32'(handle_ff) >= 32'(SLOTS) || !cur_v) status_in = spt_pkg::ST_MISS;
               else begin
                  hit_in = 1'b1; hitidx_in = cur_ff; we = 1'b1;
                  if (rd_ff.refs != 0) wr.refs = rd_ff.refs - 1'b1;
                  rip_in = rd_ff.ip; rport_in = rd_ff.port;
               end
            end else if (hit_ff) begin
               we = 1'b1; rip_in = rd_ff.ip; rport_in = rd_ff.port;
               case (op_ff) inside
                  spt_pkg::OP_GET, spt_pkg::OP_ADD: begin
                     if (rd_ff.refs != spt_pkg::REFS_MAX) wr.refs = rd_ff.refs + 1'b1;
                     if (op_ff == spt_pkg::OP_ADD && rd_ff.stamp != 0) wr.stamp = now_ff;
                  end
                  spt_pkg::OP_UPDATE: begin
                     wr.ip = ip_ff; wr.port = port_ff; wr.stamp = ntime_ff;
                     rip_in = ip_ff; rport_in = port_ff;
                  end
                  default: begin
                     if (live_ff != 0) live_in = live_ff - 1'b1;
                     if (rd_ff.refs == 0) wr.valid = 1'b0;
                     else wr.defunct = 1'b1;
                  end
               endcase
            end else if (op_ff == spt_pkg::OP_ADD) begin
               if (free_ff == (WW+1)'(WAYS)) status_in = spt_pkg::ST_FULL;
               else begin
                  addr = SW'(bkt_ff * WAYS) + SW'(free_ff);
                  we = 1'b1; wr.key = nkey; wr.ip = ip_ff; wr.port = port_ff;
                  wr.stamp = now_ff; wr.refs = 16'd1;
                  wr.valid = 1'b1; wr.defunct = 1'b0;
                  if (live_ff != spt_pkg::LIVE_MAX) live_in = live_ff + 1'b1;
                  created_in = 1'b1; hit_in = 1'b1; hitidx_in = addr;
                  rip_in = ip_ff; rport_in = port_ff;
               end
            end else status_in = spt_pkg::ST_MISS;
         end
         spt_pkg::S_SCANCHK: begin
            if (sweep_hit) begin
               we = 1'b1;
               if (!cur_d && live_ff != 0) live_in = live_ff - 1'b1;
               if (rd_ff.refs == 0) begin
                  wr.valid = 1'b0; wr.defunct = 1'b0;
               end else wr.defunct = 1'b1;
            end
            cur_in = cur_ff + 1'b1;
         end
         spt_pkg::S_SCANW: if (op_ff == spt_pkg::OP_FLUSH) live_in = '0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= spt_pkg::S_CLEAR;
         cur_ff <= '0;
         live_ff <= '0;
         ttl_ff <= '0;
         hstart_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         cur_ff <= cur_in;
         live_ff <= live_in;
         if (csr_we) ttl_ff <= csr_wdata;
         hstart_ff <= req_fire && st_in == spt_pkg::S_HASH;
      end
      way_ff <= way_in; free_ff <= free_in;
      status_ff <= status_in; created_ff <= created_in; hit_ff <= hit_in;
      hitidx_ff <= hitidx_in; rip_ff <= rip_in; rport_ff <= rport_in;
      if (st_ff == spt_pkg::S_HASH) bkt_ff <= BW'(hval % BUCKETS);
      if (req_fire) begin
         op_ff <= spt_pkg::op_type'(req_tdata[2:0]);
         key_ff <= req_tdata[66:3]; ip_ff <= req_tdata[98:67];
         port_ff <= req_tdata[114:99]; handle_ff <= req_tdata[124:115];
         ntime_ff <= req_tdata[156:125]; now_ff <= req_tdata[188:157];
      end
   end

   // Slot RAM: one port, registered read.
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wr;
      rd_ff <= mem[addr];
   end

   `SPT_ASSERT_IMP(a_ready_idle, clock, reset, req_tready, !rsp_tvalid,
      "ready while response pending")
   `SPT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "response dropped while stalled")
   `SPT_ASSERT_IMP(a_live_cap, clock, reset, 1'b1, live_ff <= 11'(SLOTS) || SLOTS > 2047,
      "live count above slot count")
endmodule

// ===== dv/tb_session_persistence_table.sv =====
// Self-checking stream testbench for the session persistence table.
`timescale 1ns / 100ps
module tb_session_persistence_table;
   localparam int SLOTS      = 1024;
   localparam int CYCLE_CAP  = 3000000;
   localparam int RAND_ITEMS = 750;

   typedef struct packed {
      spt_pkg::op_type op;
      logic [63:0] key;
      logic [31:0] ip;
      logic [15:0] port;
      logic [9:0]  handle;
      logic [31:0] ntime;
      logic [31:0] now;
   } request_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        created;
      logic [9:0]  handle;
      logic [31:0] ip;
      logic [15:0] port;
      logic [10:0] live;
   } reply_type;

   typedef struct {
      request_type req;
      bit          typed;
      reply_type   want;
   } table_row_type;

   logic         clock;
   logic         reset;
   logic         csr_we;
   logic [31:0]  csr_wdata;
   logic         req_tvalid;
   logic         req_tready;
   logic [191:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [71:0]  rsp_tdata;

   session_persistence_table dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // Shadow copy of the session table, updated as each request is accepted.
   logic [31:0] ttl_shadow;
   bit          sh_valid   [SLOTS];
   bit          sh_defunct [SLOTS];
   logic [63:0] sh_key     [SLOTS];
   logic [31:0] sh_ip      [SLOTS];
   logic [15:0] sh_port    [SLOTS];
   logic [31:0] sh_stamp   [SLOTS];
   logic [15:0] sh_refs    [SLOTS];
   logic [10:0] sh_live;

   reply_type   pending_replies[$];
   logic [9:0]  known_handles[$];
   logic [63:0] key_pool[$];
   logic [31:0] be_ip[4];
   logic [15:0] be_port[4];
   int          errors = 0;
   longint      cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Bound the run: a hung handshake ends as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Strip bytes past the first zero byte; they take no part in hash or compare.
   function automatic logic [63:0] trim_key(logic [63:0] k);
      logic [63:0] r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         if (k[8*i +: 8] == 8'd0) break;
         r[8*i +: 8] = k[8*i +: 8];
      end
      return r;
   endfunction

   // djb2 over the trimmed key, reduced to one of 256 buckets.
   function automatic logic [7:0] djb2_bucket(logic [63:0] nk);
      logic [31:0] h;
      h = 32'd5381;
      for (int i = 0; i < 8; i++) begin
         if (nk[8*i +: 8] == 8'd0) break;
         h = h * 32'd33 + {24'd0, nk[8*i +: 8]};
      end
      return h[7:0];
   endfunction

   function automatic int lookup_slot(logic [63:0] nk);
      int base;
      base = djb2_bucket(nk) * 4;
      for (int w = 0; w < 4; w++)
         if (sh_valid[base+w] && !sh_defunct[base+w] && sh_key[base+w] == nk)
            return base + w;
      return -1;
   endfunction

   function automatic void free_session(int s);
      if (!sh_defunct[s] && sh_live > 0) sh_live = sh_live - 11'd1;
      if (sh_refs[s] == 16'd0) begin
         sh_valid[s]   = 1'b0;
         sh_defunct[s] = 1'b0;
      end else begin
         sh_defunct[s] = 1'b1;
      end
   endfunction

   function automatic void bump_refs(int s);
      if (sh_refs[s] != spt_pkg::REFS_MAX) sh_refs[s] = sh_refs[s] + 16'd1;
   endfunction

   // Apply one request to the shadow table and return the reply it must produce.
   function automatic reply_type apply_request(request_type r);
      reply_type   o;
      logic [63:0] nk;
      int          hit, f, base, w;
      o   = '0;
      hit = -1;
      nk  = trim_key(r.key);
      case (r.op)
         spt_pkg::OP_GET: begin
            f = lookup_slot(nk);
            if (f < 0) o.status = spt_pkg::ST_MISS;
            else begin
               bump_refs(f);
               hit = f;
            end
         end
         spt_pkg::OP_ADD: begin
            f = lookup_slot(nk);
            if (f >= 0) begin
               if (sh_stamp[f] != 0) sh_stamp[f] = r.now;
               bump_refs(f);
               hit = f;
            end else begin
               base = djb2_bucket(nk) * 4;
               for (w = 0; w < 4; w++) if (!sh_valid[base+w]) break;
               if (w == 4) o.status = spt_pkg::ST_FULL;
               else begin
                  f = base + w;
                  sh_valid[f]   = 1'b1;
                  sh_defunct[f] = 1'b0;
                  sh_key[f]     = nk;
                  sh_ip[f]      = r.ip;
                  sh_port[f]    = r.port;
                  sh_stamp[f]   = r.now;
                  sh_refs[f]    = 16'd1;
                  if (sh_live < spt_pkg::LIVE_MAX) sh_live = sh_live + 11'd1;
                  o.created = 1'b1;
                  hit = f;
               end
            end
         end
         spt_pkg::OP_RELEASE: begin
            if (!sh_valid[r.handle]) o.status = spt_pkg::ST_MISS;
            else begin
               if (sh_refs[r.handle] != 0) sh_refs[r.handle] = sh_refs[r.handle] - 16'd1;
               hit = int'(r.handle);
            end
         end
         spt_pkg::OP_DELETE: begin
            f = lookup_slot(nk);
            if (f < 0) o.status = spt_pkg::ST_MISS;
            else begin
               hit = f;
               free_session(f);
            end
         end
         spt_pkg::OP_UPDATE: begin
            f = lookup_slot(nk);
            if (f < 0) o.status = spt_pkg::ST_MISS;
            else begin
               sh_ip[f]    = r.ip;
               sh_port[f]  = r.port;
               sh_stamp[f] = r.ntime;
               hit = f;
            end
         end
         spt_pkg::OP_EXPIRE: begin
            // stamps in the future never expire
            for (int s = 0; s < SLOTS; s++)
               if (sh_valid[s] && sh_stamp[s] != 0 && r.now >= sh_stamp[s] &&
                   (r.now - sh_stamp[s]) > ttl_shadow)
                  free_session(s);
         end
         spt_pkg::OP_DEL_BE: begin
            for (int s = 0; s < SLOTS; s++)
               if (sh_valid[s] && sh_ip[s] == r.ip && sh_port[s] == r.port)
                  free_session(s);
         end
         default: begin
            for (int s = 0; s < SLOTS; s++) if (sh_valid[s]) free_session(s);
            sh_live = '0;
         end
      endcase
      if (hit >= 0) begin
         o.handle = hit[9:0];
         o.ip     = sh_ip[hit];
         o.port   = sh_port[hit];
      end
      o.live = sh_live;
      return o;
   endfunction

   // Check each reply against the oldest outstanding prediction.
   always @(posedge clock) begin
      reply_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{status: rsp_tdata[1:0], created: rsp_tdata[2], handle: rsp_tdata[12:3],
                 ip: rsp_tdata[44:13], port: rsp_tdata[60:45], live: rsp_tdata[71:61]};
         if (pending_replies.size() == 0) begin
            $error("reply with nothing outstanding: %h", rsp_tdata);
            errors++;
         end else begin
            want = pending_replies.pop_front();
            if (got.status != want.status) begin
               $error("status: expected %0d got %0d", want.status, got.status); errors++;
            end
            if (got.created != want.created) begin
               $error("created: expected %0d got %0d", want.created, got.created); errors++;
            end
            if (got.handle != want.handle) begin
               $error("result_handle: expected %0d got %0d", want.handle, got.handle);
               errors++;
            end
            if (got.ip != want.ip) begin
               $error("found_ip: expected %h got %h", want.ip, got.ip); errors++;
            end
            if (got.port != want.port) begin
               $error("found_port: expected %h got %h", want.port, got.port); errors++;
            end
            if (got.live != want.live) begin
               $error("live_sessions: expected %0d got %0d", want.live, got.live); errors++;
            end
         end
      end
   end

   // Receiver: random stalls, stretches of steady ready, and one long hold-off
   // while the sender keeps pushing so the block backs up.
   initial begin
      int stall_left;
      bit long_done;
      stall_left = 0;
      long_done  = 0;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!long_done && cycle_count > 4000) begin
            long_done  = 1;
            stall_left = 2500;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if ((cycle_count % 3000) < 500) begin
            rsp_tready <= 1'b1;
         end else if ($urandom_range(0, 99) < 25) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                     : $urandom_range(1, 3);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Hold the request until accepted, record its prediction, optionally idle.
   task automatic send_request(request_type r, bit typed, reply_type want, bit no_gap);
      reply_type p;
      int        gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, r.now, r.ntime, r.handle, r.port, r.ip, r.key, r.op};
      do @(posedge clock); while (!req_tready);
      p = apply_request(r);
      pending_replies.push_back(typed ? want : p);
      if (p.status == spt_pkg::ST_OK && (r.op == spt_pkg::OP_ADD || r.op == spt_pkg::OP_GET))
         known_handles.push_back(p.handle);
      if (known_handles.size() > 64) void'(known_handles.pop_front());
      gap = 0;
      if (!no_gap) begin
         case ($urandom_range(0, 9))
            0, 1, 2: gap = $urandom_range(1, 3);
            3:       gap = $urandom_range(8, 40);
            default: gap = 0;
         endcase
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Write time_to_live only with nothing in flight.
   task automatic write_ttl(logic [31:0] v);
      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      ttl_shadow = v;
   endtask

   // Scatter random bytes past the terminating zero; they must be ignored.
   function automatic logic [63:0] pad_junk(logic [63:0] nk);
      logic [63:0] k;
      bit          seen_zero;
      k = nk;
      seen_zero = 0;
      for (int i = 0; i < 8; i++) begin
         if (seen_zero && $urandom_range(0, 1)) k[8*i +: 8] = 8'($urandom_range(0, 255));
         if (nk[8*i +: 8] == 8'd0) seen_zero = 1;
      end
      return k;
   endfunction

   function automatic request_type mk(spt_pkg::op_type op, logic [63:0] key,
                                      logic [31:0] ip, logic [15:0] port,
                                      logic [9:0] handle, logic [31:0] ntime,
                                      logic [31:0] now);
      return '{op: op, key: key, ip: ip, port: port, handle: handle,
               ntime: ntime, now: now};
   endfunction

   initial begin
      table_row_type rows[$];
      table_row_type row;
      request_type   r;
      reply_type     none;
      logic [63:0]   k, key_a, full_key;
      logic [63:0]   collide[$];
      logic [31:0]   now_t;
      logic [31:0]   ttl_list[4];
      int            pick, len;
      bit            burst;

      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      ttl_shadow = '0;
      sh_live = '0;
      for (int s = 0; s < SLOTS; s++) begin
         sh_valid[s] = 0;
         sh_defunct[s] = 0;
      end
      none = '0;

      // Find two-byte keys that all land in one bucket, to fill it up.
      for (int b0 = 1; b0 < 256 && collide.size() < 6; b0++)
         for (int b1 = 1; b1 < 256 && collide.size() < 6; b1++) begin
            k = {48'd0, b1[7:0], b0[7:0]};
            if (djb2_bucket(k) == 8'h5A) collide.push_back(k);
         end
      key_a    = 64'h0000_0000_0041_4243;
      full_key = 64'hFFFF_FFFF_FFFF_FFFF;
      foreach (collide[i]) key_pool.push_back(collide[i]);
      key_pool.push_back(key_a);
      key_pool.push_back(full_key);
      key_pool.push_back(64'd0);
      for (int i = 0; i < 40; i++) begin
         len = $urandom_range(1, 8);
         k = '0;
         for (int j = 0; j < len; j++) k[8*j +: 8] = 8'($urandom_range(1, 255));
         key_pool.push_back(k);
      end
      for (int i = 0; i < 4; i++) begin
         be_ip[i]   = $urandom();
         be_port[i] = 16'($urandom_range(0, 65535));
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table; typed replies only where they are obvious.
      row = '{mk(spt_pkg::OP_GET, key_a, 0, 0, 0, 0, 1), 1,
              '{spt_pkg::ST_MISS, 0, 0, 0, 0, 0}};
      rows.push_back(row);
      row = '{mk(spt_pkg::OP_RELEASE, 0, 0, 0, 10'h3FF, 0, 1), 1,
              '{spt_pkg::ST_MISS, 0, 0, 0, 0, 0}};
      rows.push_back(row);
      rows.push_back('{mk(spt_pkg::OP_ADD, key_a, '1, '1, 0, 0, 100), 0, none});
      rows.push_back('{mk(spt_pkg::OP_ADD, key_a, 0, 0, 0, 0, 110), 0, none});
      rows.push_back('{mk(spt_pkg::OP_GET, key_a, 0, 0, 0, 0, 120), 0, none});
      rows.push_back('{mk(spt_pkg::OP_UPDATE, key_a, 0, 0, 0, 0, 130), 0, none});
      rows.push_back('{mk(spt_pkg::OP_ADD, 64'd0, 32'h0A00_0001, 16'd80, 0, 0, '1),
                       0, none});
      rows.push_back('{mk(spt_pkg::OP_ADD, key_a | 64'hA5C3_0000_0000_0000, 0, 0, 0, 0,
                          140), 0, none});
      for (int i = 0; i < 5; i++)
         rows.push_back('{mk(spt_pkg::OP_ADD, collide[i], be_ip[0], be_port[0], 0, 0,
                             150 + i), 0, none});
      rows.push_back('{mk(spt_pkg::OP_RELEASE, 0, 0, 0, {djb2_bucket(key_a), 2'b00}, 0,
                          160), 0, none});
      rows.push_back('{mk(spt_pkg::OP_DELETE, key_a, 0, 0, 0, 0, 170), 0, none});
      rows.push_back('{mk(spt_pkg::OP_GET, key_a, 0, 0, 0, 0, 175), 0, none});
      rows.push_back('{mk(spt_pkg::OP_RELEASE, 0, 0, 0, {djb2_bucket(key_a), 2'b00}, 0,
                          180), 0, none});
      rows.push_back('{mk(spt_pkg::OP_DEL_BE, 0, be_ip[0], be_port[0], 0, 0, 190),
                       0, none});
      rows.push_back('{mk(spt_pkg::OP_ADD, full_key, '1, '1, 10'h3FF, '1, 200), 0, none});
      rows.push_back('{mk(spt_pkg::OP_UPDATE, 64'h77, 0, 0, 0, '1, 210), 0, none});
      rows.push_back('{mk(spt_pkg::OP_DELETE, 64'h77, 0, 0, 0, 0, 220), 0, none});
      rows.push_back('{mk(spt_pkg::OP_EXPIRE, 0, 0, 0, 0, 0, 32'd5000), 0, none});
      row = '{mk(spt_pkg::OP_FLUSH, 0, 0, 0, 0, 0, 5001), 1,
              '{spt_pkg::ST_OK, 0, 0, 0, 0, 0}};
      rows.push_back(row);
      row = '{mk(spt_pkg::OP_GET, full_key, 0, 0, 0, 0, 5002), 1,
              '{spt_pkg::ST_MISS, 0, 0, 0, 0, 0}};
      rows.push_back(row);

      write_ttl(32'd0);
      foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].want, 0);

      // Random phases, each with its own time-to-live.
      ttl_list = '{32'hFFFF_FFFF, 32'd30, 32'd0, $urandom()};
      now_t = 32'd10000;
      for (int ph = 0; ph < 4; ph++) begin
         write_ttl(ttl_list[ph]);
         for (int n = 0; n < RAND_ITEMS / 4; n++) begin
            burst = (n % 60) < 15;
            now_t = now_t + $urandom_range(0, 20);
            if ($urandom_range(0, 39) == 0) now_t = $urandom();
            r = mk(spt_pkg::OP_GET,
                   pad_junk(key_pool[$urandom_range(0, key_pool.size() - 1)]),
                   0, 0, 10'($urandom_range(0, 1023)), 0, now_t);
            if ($urandom_range(0, 9) == 0) r.key = {$urandom(), $urandom()};
            pick = $urandom_range(0, 3);
            if ($urandom_range(0, 6) == 0) begin
               r.ip   = $urandom();
               r.port = 16'($urandom_range(0, 65535));
            end else begin
               r.ip   = be_ip[pick];
               r.port = be_port[pick];
            end
            case ($urandom_range(0, 3))
               0:       r.ntime = 0;
               1:       r.ntime = $urandom();
               default: r.ntime = now_t - $urandom_range(0, 60);
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 20)      r.op = spt_pkg::OP_GET;
            else if (pick < 46) r.op = spt_pkg::OP_ADD;
            else if (pick < 60) r.op = spt_pkg::OP_RELEASE;
            else if (pick < 72) r.op = spt_pkg::OP_DELETE;
            else if (pick < 85) r.op = spt_pkg::OP_UPDATE;
            else if (pick < 92) r.op = spt_pkg::OP_EXPIRE;
            else if (pick < 97) r.op = spt_pkg::OP_DEL_BE;
            else                r.op = spt_pkg::OP_FLUSH;
            if (r.op == spt_pkg::OP_RELEASE && known_handles.size() != 0 &&
                $urandom_range(0, 4) != 0)
               r.handle = known_handles[$urandom_range(0, known_handles.size() - 1)];
            send_request(r, 0, none, burst);
         end
      end
      req_tvalid <= 1'b0;

      while (pending_replies.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/spt_pkg.sv
rtl/spt_hash.sv
rtl/session_persistence_table.sv
dv/tb_session_persistence_table.sv
